### design/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg: shared types and constants for the CSV field tokeniser
// Byte classes, token struct and output kind codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cft_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_END  = 1'b1;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [2:0] {
    OP_TEXT,
    OP_QUOTE,
    OP_COMMA,
    OP_LF,
    OP_CR,
    OP_EOI
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } tok_t;

endpackage

### design/cft_front.sv
// ----------------------------------------------------------------------------
// cft_front: input side of the tokeniser
// Accepts requests and classifies each byte into a token for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cft_front (
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_mode,
  input  logic [7:0]    in_data_byte,
  input  logic          q_full,
  output logic          q_push,
  output cft_pkg::tok_t q_tok
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_tok.data = in_data_byte;
    if (in_mode == cft_pkg::MODE_END) begin
      q_tok.op = cft_pkg::OP_EOI;
    end else begin
      case (in_data_byte)
        cft_pkg::CH_QUOTE: q_tok.op = cft_pkg::OP_QUOTE;
        cft_pkg::CH_COMMA: q_tok.op = cft_pkg::OP_COMMA;
        cft_pkg::CH_LF:    q_tok.op = cft_pkg::OP_LF;
        cft_pkg::CH_CR:    q_tok.op = cft_pkg::OP_CR;
        default:           q_tok.op = cft_pkg::OP_TEXT;
      endcase
    end
  end

endmodule

### design/cft_queue.sv
// ----------------------------------------------------------------------------
// cft_queue: two-entry token queue
// Decouples the classifier from the parser so each side can stall alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cft_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cft_pkg::tok_t push_tok,
  input  logic          pop,
  output cft_pkg::tok_t pop_tok,
  output logic          empty,
  output logic          full
);

  cft_pkg::tok_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign empty   = (count_r == 2'd0);
  assign full    = (count_r == 2'd2);
  assign pop_tok = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue pushed while full");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2) else $error("queue count out of range");

endmodule

### design/cft_back.sv
// ----------------------------------------------------------------------------
// cft_back: parser state and result register
// Applies one token per cycle to the quote and counter state while the output register is free or being drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cft_back #(
  parameter int CELL_BYTES   = 256,
  parameter int ROW_LIMIT    = 1024,
  parameter int COLUMN_LIMIT = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  cft_pkg::tok_t q_tok,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_kind,
  output logic [9:0]    out_row,
  output logic [5:0]    out_column,
  output logic [7:0]    out_position,
  output logic [7:0]    out_char_byte
);

  localparam int FL_W  = $clog2(CELL_BYTES);
  localparam int ROW_W = $clog2(ROW_LIMIT + 1);
  localparam int COL_W = $clog2(COLUMN_LIMIT + 1);
  localparam logic [FL_W-1:0]  FL_MAX  = FL_W'(CELL_BYTES - 1);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROW_LIMIT);
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMN_LIMIT);

  logic             qm_r, qm_nxt;
  logic             qp_r, qp_nxt;
  logic [FL_W-1:0]  fl_r, fl_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r;
  logic [9:0]       out_row_r;
  logic [5:0]       out_column_r;
  logic [7:0]       out_position_r;
  logic [7:0]       out_char_r;

  logic             advance;
  logic             in_lim;
  logic             unq;
  logic             do_keep;
  logic             do_close;
  logic             res_valid;
  logic             res_kind;
  logic [31:0]      res_pos_ext;
  logic [31:0]      row_ext;
  logic [31:0]      col_ext;

  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = advance && !q_empty;
  assign in_lim  = (row_r < ROW_MAX) && (col_r < COL_MAX);
  assign row_ext = 32'(row_r);
  assign col_ext = 32'(col_r);

  always_comb begin
    qm_nxt    = qm_r;
    qp_nxt    = qp_r;
    fl_nxt    = fl_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    unq       = 1'b0;
    do_keep   = 1'b0;
    do_close  = 1'b0;
    res_valid = 1'b0;
    res_kind  = cft_pkg::KIND_CHAR;
    res_pos_ext = 32'(fl_r);

    if (q_tok.op == cft_pkg::OP_EOI) begin
      do_close = 1'b1;
    end else if (qp_r) begin
      qp_nxt = 1'b0;
      if (q_tok.op == cft_pkg::OP_QUOTE) begin
        do_keep = 1'b1;
      end else begin
        qm_nxt = 1'b0;
        unq    = 1'b1;
      end
    end else if (qm_r) begin
      if (q_tok.op == cft_pkg::OP_QUOTE) begin
        qp_nxt = 1'b1;
      end else begin
        do_keep = 1'b1;
      end
    end else begin
      unq = 1'b1;
    end

    if (unq) begin
      case (q_tok.op)
        cft_pkg::OP_QUOTE: begin
          if (fl_r == '0) begin
            qm_nxt = 1'b1;
          end else begin
            do_keep = 1'b1;
          end
        end
        cft_pkg::OP_COMMA: begin
          do_close = 1'b1;
          if (col_r < COL_MAX) begin
            col_nxt = col_r + COL_W'(1);
          end
        end
        cft_pkg::OP_LF: begin
          do_close = 1'b1;
          col_nxt  = '0;
          if (row_r < ROW_MAX) begin
            row_nxt = row_r + ROW_W'(1);
          end
        end
        cft_pkg::OP_CR: begin
        end
        default: begin
          do_keep = 1'b1;
        end
      endcase
    end

    // a full cell still parses but keeps nothing
    if (do_keep && (fl_r < FL_MAX)) begin
      fl_nxt    = fl_r + FL_W'(1);
      res_valid = in_lim;
    end

    if (do_close) begin
      fl_nxt    = '0;
      res_valid = (fl_r != '0) && in_lim;
      res_kind  = cft_pkg::KIND_DONE;
    end

    // end of input returns all parser state to reset
    if (q_tok.op == cft_pkg::OP_EOI) begin
      qm_nxt  = 1'b0;
      qp_nxt  = 1'b0;
      row_nxt = '0;
      col_nxt = '0;
    end

    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r        <= 1'b0;
      qp_r        <= 1'b0;
      fl_r        <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        qm_r  <= qm_nxt;
        qp_r  <= qp_nxt;
        fl_r  <= fl_nxt;
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_kind_r     <= res_kind;
      out_row_r      <= row_ext[9:0];
      out_column_r   <= col_ext[5:0];
      out_position_r <= res_pos_ext[7:0];
      out_char_r     <= (res_kind == cft_pkg::KIND_DONE) ? 8'h00 : q_tok.data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_row       = out_row_r;
  assign out_column    = out_column_r;
  assign out_position  = out_position_r;
  assign out_char_byte = out_char_r;

  a_pending_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    qp_r |-> qm_r) else $error("pending quote outside quoted mode");

  a_field_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fl_r <= FL_MAX) else $error("field length past cell limit");

  a_counters_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r <= ROW_MAX) && (col_r <= COL_MAX)) else $error("counter past limit");

  a_eoi_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_tok.op == cft_pkg::OP_EOI)) |=>
      (fl_r == '0) && !qm_r && !qp_r && (row_r == '0) && (col_r == '0))
    else $error("end of input left state behind");

endmodule

### design/csv_field_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer: streaming CSV cell tokeniser
// Splits a byte stream into cell characters and cell-complete markers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request per byte, in_mode = 0
//   with the byte on in_data_byte, or in_mode = 1 to mark end of input.
//   Output channel (out_valid / out_stall): a request per kept cell
//   character (out_kind = 0) or per finished non-empty cell (out_kind = 1,
//   out_position = cell length), both only inside the row/column limits.
//   Bytes that yield nothing produce no request.
//   Throughput: one byte per cycle while the output is not stalled; the
//   parser applies one token per cycle while the output register is free.
//   An accepted byte is first written into the queue; the parser then pops
//   it and loads its result into the output register.
//   Stall: out_stall holds the output register; the two-entry queue absorbs
//   in-flight bytes and in_stall rises when it is full.
//   Reset: rst_n low (synchronous) empties the queue, clears quote state,
//   field length and row/column counters. An end-of-input request does the
//   same for the parser state after flushing the last cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csv_field_tokenizer #(
  parameter int CELL_BYTES   = 256,
  parameter int ROW_LIMIT    = 1024,
  parameter int COLUMN_LIMIT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [9:0] out_row,
  output logic [5:0] out_column,
  output logic [7:0] out_position,
  output logic [7:0] out_char_byte
);

  // classified tokens flow front -> queue -> back
  cft_pkg::tok_t push_tok;
  cft_pkg::tok_t pop_tok;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  logic          q_full;

  cft_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_tok        (push_tok)
  );

  cft_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tok (push_tok),
    .pop      (q_pop),
    .pop_tok  (pop_tok),
    .empty    (q_empty),
    .full     (q_full)
  );

  // parser pops a queued token whenever the output register is free or being drained
  cft_back #(
    .CELL_BYTES   (CELL_BYTES),
    .ROW_LIMIT    (ROW_LIMIT),
    .COLUMN_LIMIT (COLUMN_LIMIT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_tok         (pop_tok),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_row       (out_row),
    .out_column    (out_column),
    .out_position  (out_position),
    .out_char_byte (out_char_byte)
  );

endmodule

### test/csv_field_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_tb: self-checking bench for the CSV field tokeniser
// Drives byte and end-of-input requests with random gaps and output stalls,
// predicts every cell character and cell-complete request in order, and
// compares them field by field as they leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csv_field_tokenizer_tb;

  localparam int CELL_BYTES   = 256;
  localparam int ROW_LIMIT    = 1024;
  localparam int COLUMN_LIMIT = 64;

  localparam int RANDOM_ITEMS = 815;
  localparam int CALM_ITEMS   = 150;   // stretch with no gaps and no stalls
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  // One result of the tokeniser, laid out as the output ports.
  typedef struct packed {
    logic       kind;
    logic [9:0] row;
    logic [5:0] column;
    logic [7:0] position;
    logic [7:0] char_byte;
  } cell_tok_t;

  // Directed row: pinned rows carry the result typed in by hand, the rest
  // take whatever the predictor says.
  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       pinned;
    logic       has_tok;
    cell_tok_t  tok;
  } dir_step_t;

  typedef enum int {
    SHAPE_EMPTY,
    SHAPE_PLAIN,
    SHAPE_QUOTED,
    SHAPE_STRAY,    // plain text with delimiters and quotes sprinkled in
    SHAPE_BROKEN    // quoted text with trailing bytes after the close
  } cell_shape_t;

  localparam cell_tok_t NO_TOK = '0;
  localparam int DIR_LEN = 28;

  localparam dir_step_t DIR_STEPS [DIR_LEN] = '{
    // plain cell with extreme bytes, dropped CR, then an empty cell
    '{cft_pkg::MODE_DATA, 8'h61, 1'b1, 1'b1,
      '{cft_pkg::KIND_CHAR, 10'd0, 6'd0, 8'd0, 8'h61}},
    '{cft_pkg::MODE_DATA, 8'h00, 1'b1, 1'b1,
      '{cft_pkg::KIND_CHAR, 10'd0, 6'd0, 8'd1, 8'h00}},
    '{cft_pkg::MODE_DATA, 8'hFF, 1'b1, 1'b1,
      '{cft_pkg::KIND_CHAR, 10'd0, 6'd0, 8'd2, 8'hFF}},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_CR,    1'b1, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_COMMA, 1'b1, 1'b1,
      '{cft_pkg::KIND_DONE, 10'd0, 6'd0, 8'd3, 8'h00}},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_COMMA, 1'b1, 1'b0, NO_TOK},
    // quoted cell: CR, comma and LF kept, doubled quote, close then text
    '{cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE, 1'b1, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_CR,    1'b0, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_COMMA, 1'b0, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_LF,    1'b0, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE, 1'b1, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE, 1'b0, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE, 1'b1, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, 8'h78,             1'b0, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE, 1'b0, 1'b0, NO_TOK},  // quote mid-field is text
    '{cft_pkg::MODE_DATA, cft_pkg::CH_LF,    1'b0, 1'b0, NO_TOK},
    // end of input while a quote is pending closes it
    '{cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE, 1'b1, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, 8'h71,             1'b0, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE, 1'b1, 1'b0, NO_TOK},
    '{cft_pkg::MODE_END,  8'hFF,             1'b0, 1'b0, NO_TOK},
    // end of input inside open quotes flushes the cell
    '{cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE, 1'b1, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, 8'h7A,             1'b0, 1'b0, NO_TOK},
    '{cft_pkg::MODE_END,  8'h00,             1'b0, 1'b0, NO_TOK},
    // empty line, empty quoted cell, end of input on an empty cell
    '{cft_pkg::MODE_DATA, cft_pkg::CH_LF,    1'b1, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE, 1'b1, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE, 1'b1, 1'b0, NO_TOK},
    '{cft_pkg::MODE_DATA, cft_pkg::CH_COMMA, 1'b1, 1'b0, NO_TOK},
    '{cft_pkg::MODE_END,  8'h80,             1'b1, 1'b0, NO_TOK}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_mode = cft_pkg::MODE_DATA;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [9:0] out_row;
  logic [5:0] out_column;
  logic [7:0] out_position;
  logic [7:0] out_char_byte;

  csv_field_tokenizer #(
    .CELL_BYTES(CELL_BYTES),
    .ROW_LIMIT(ROW_LIMIT),
    .COLUMN_LIMIT(COLUMN_LIMIT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_data_byte(in_data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_row(out_row),
    .out_column(out_column),
    .out_position(out_position),
    .out_char_byte(out_char_byte)
  );

  always #2 clk = ~clk;

  // Parser state as the predictor sees it, starting from reset.
  logic        quote_open = 1'b0;
  logic        quote_seen = 1'b0;   // quote inside quotes, next byte decides
  logic [7:0]  cell_len   = '0;
  logic [10:0] row_cnt    = '0;
  logic [6:0]  col_cnt    = '0;

  cell_tok_t pending_tokens [$];
  int        err_count   = 0;
  int        sent_items  = 0;
  int        cycle_count = 0;
  bit        calm        = 1'b0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic bit in_grid();
    return (row_cnt < ROW_LIMIT) && (col_cnt < COLUMN_LIMIT);
  endfunction

  function automatic cell_tok_t make_tok(input logic k, input logic [7:0] pos,
                                         input logic [7:0] ch);
    cell_tok_t t;
    t.kind      = k;
    t.row       = row_cnt[9:0];
    t.column    = col_cnt[5:0];
    t.position  = pos;
    t.char_byte = ch;
    return t;
  endfunction

  // Cell full: the byte is still parsed but nothing is kept or emitted.
  function automatic bit keep_char(input logic [7:0] c, output cell_tok_t t);
    logic [7:0] off;
    t = NO_TOK;
    if (cell_len >= CELL_BYTES - 1) return 1'b0;
    off = cell_len;
    cell_len = cell_len + 8'd1;
    if (!in_grid()) return 1'b0;
    t = make_tok(cft_pkg::KIND_CHAR, off, c);
    return 1'b1;
  endfunction

  // Empty cells and cells outside the grid close silently.
  function automatic bit close_cell(output cell_tok_t t);
    bit hit;
    t = NO_TOK;
    hit = (cell_len != 0) && in_grid();
    if (hit) t = make_tok(cft_pkg::KIND_DONE, cell_len, 8'h00);
    cell_len = '0;
    return hit;
  endfunction

  function automatic bit tokenise_byte(input logic m, input logic [7:0] c,
                                       output cell_tok_t t);
    bit hit;
    t = NO_TOK;
    if (m == cft_pkg::MODE_END) begin
      // a pending quote simply counts as the close here
      hit = close_cell(t);
      quote_open = 1'b0;
      quote_seen = 1'b0;
      row_cnt    = '0;
      col_cnt    = '0;
      return hit;
    end
    if (quote_seen) begin
      quote_seen = 1'b0;
      if (c == cft_pkg::CH_QUOTE) return keep_char(c, t);
      quote_open = 1'b0;   // lone quote closed; byte falls through as text
    end else if (quote_open) begin
      if (c == cft_pkg::CH_QUOTE) begin
        quote_seen = 1'b1;
        return 1'b0;
      end
      return keep_char(c, t);
    end
    if (c == cft_pkg::CH_QUOTE && cell_len == 0) begin
      quote_open = 1'b1;
      return 1'b0;
    end
    if (c == cft_pkg::CH_COMMA) begin
      hit = close_cell(t);
      if (col_cnt < COLUMN_LIMIT) col_cnt = col_cnt + 7'd1;
      return hit;
    end
    if (c == cft_pkg::CH_LF) begin
      hit = close_cell(t);
      col_cnt = '0;
      if (row_cnt < ROW_LIMIT) row_cnt = row_cnt + 11'd1;
      return hit;
    end
    if (c == cft_pkg::CH_CR) return 1'b0;
    return keep_char(c, t);
  endfunction

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------

  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < 31);
  endfunction

  // Payload only moves once the request has been taken.
  task automatic drive_request(input logic m, input logic [7:0] d);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= m;
    in_data_byte <= d;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  task automatic send_byte(input logic m, input logic [7:0] d);
    cell_tok_t t;
    if (tokenise_byte(m, d, t)) pending_tokens.push_back(t);
    drive_request(m, d);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == cft_pkg::CH_QUOTE || c == cft_pkg::CH_COMMA ||
           c == cft_pkg::CH_LF || c == cft_pkg::CH_CR);
    return c;
  endfunction

  // Heavy on the four special bytes.
  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 5))
      0:       return cft_pkg::CH_QUOTE;
      1:       return cft_pkg::CH_COMMA;
      2:       return cft_pkg::CH_LF;
      3:       return cft_pkg::CH_CR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Quoted body, quotes doubled so the cell stays well formed.
  task automatic send_quoted(input int len);
    logic [7:0] c;
    send_byte(cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE);
    for (int i = 0; i < len; i++) begin
      c = ($urandom_range(0, 3) == 0) ? noise_char() : 8'($urandom_range(0, 255));
      send_byte(cft_pkg::MODE_DATA, c);
      if (c == cft_pkg::CH_QUOTE) send_byte(cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE);
    end
    send_byte(cft_pkg::MODE_DATA, cft_pkg::CH_QUOTE);
  endtask

  task automatic send_cell(input cell_shape_t shape, input int len);
    case (shape)
      SHAPE_EMPTY: ;
      SHAPE_PLAIN: begin
        for (int i = 0; i < len; i++) send_byte(cft_pkg::MODE_DATA, plain_char());
      end
      SHAPE_QUOTED: send_quoted(len);
      SHAPE_STRAY: begin
        send_byte(cft_pkg::MODE_DATA, plain_char());
        for (int i = 0; i < len; i++)
          send_byte(cft_pkg::MODE_DATA,
                    ($urandom_range(0, 3) == 0) ? noise_char() : plain_char());
      end
      SHAPE_BROKEN: begin
        send_quoted(len);
        for (int i = 0; i < $urandom_range(1, 3); i++)
          send_byte(cft_pkg::MODE_DATA, plain_char());
      end
      default: ;
    endcase
  endtask

  // One CSV row; a free ending may be LF, CRLF, end of input or nothing at all.
  task automatic send_record(input int cells, input bit long_cell, input bit free_end);
    cell_shape_t shape;
    int          pick;
    int          len;
    for (int k = 0; k < cells; k++) begin
      if (k > 0) send_byte(cft_pkg::MODE_DATA, cft_pkg::CH_COMMA);
      if (long_cell && k == 0) begin
        // runs past the cell limit so the tail is dropped
        shape = ($urandom_range(0, 1) == 0) ? SHAPE_PLAIN : SHAPE_QUOTED;
        len   = $urandom_range(256, 300);
      end else begin
        pick  = $urandom_range(0, 99);
        shape = (pick < 15) ? SHAPE_EMPTY  :
                (pick < 55) ? SHAPE_PLAIN  :
                (pick < 80) ? SHAPE_QUOTED :
                (pick < 92) ? SHAPE_STRAY  : SHAPE_BROKEN;
        len   = $urandom_range(1, 8);
      end
      send_cell(shape, len);
    end
    pick = free_end ? $urandom_range(0, 9) : 9;
    case (pick)
      0: send_byte(cft_pkg::MODE_END, 8'($urandom_range(0, 255)));
      1, 2: begin
        send_byte(cft_pkg::MODE_DATA, cft_pkg::CH_CR);
        send_byte(cft_pkg::MODE_DATA, cft_pkg::CH_LF);
      end
      3: ;   // row runs on into the next record
      default: send_byte(cft_pkg::MODE_DATA, cft_pkg::CH_LF);
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // Handshake signals are read before the edge takes effect, so this sees
  // exactly the request the block hands over at this edge.
  always @(posedge clk) begin : result_check
    cell_tok_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_tokens.size() == 0) begin
          report_mismatch("unexpected request, position", int'(out_position), 0);
        end else begin
          want = pending_tokens.pop_front();
          if (out_kind !== want.kind)
            report_mismatch("kind", int'(out_kind), int'(want.kind));
          if (out_row !== want.row)
            report_mismatch("row", int'(out_row), int'(want.row));
          if (out_column !== want.column)
            report_mismatch("column", int'(out_column), int'(want.column));
          if (out_position !== want.position)
            report_mismatch("position", int'(out_position), int'(want.position));
          if (out_char_byte !== want.char_byte)
            report_mismatch("char_byte", int'(out_char_byte), int'(want.char_byte));
        end
      end
      out_stall <= idle_roll();
    end
  end

  // Watchdog: covers a hung handshake and results that never turn up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL csv_field_tokenizer");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  initial begin : stimulus
    cell_tok_t t;
    bit        hit;
    int        rec;
    int        calm_from;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: state advances through the predictor on every row
    for (int i = 0; i < DIR_LEN; i++) begin
      hit = tokenise_byte(DIR_STEPS[i].mode, DIR_STEPS[i].data, t);
      if (DIR_STEPS[i].pinned) begin
        if (DIR_STEPS[i].has_tok) pending_tokens.push_back(DIR_STEPS[i].tok);
      end else if (hit) begin
        pending_tokens.push_back(t);
      end
      drive_request(DIR_STEPS[i].mode, DIR_STEPS[i].data);
    end

    // random rows, mostly well formed, with noise bursts mixed in
    calm_from = sent_items + 250;
    rec = 0;
    while (sent_items < DIR_LEN + RANDOM_ITEMS) begin
      calm = (sent_items >= calm_from) && (sent_items < calm_from + CALM_ITEMS);
      if (rec == 6) begin
        // wide row: columns past the limit go silent and the counter saturates
        send_record($urandom_range(COLUMN_LIMIT, COLUMN_LIMIT + 6), 1'b0, 1'b0);
      end else if ($urandom_range(0, 9) == 0) begin
        for (int i = 0; i < $urandom_range(4, 16); i++) begin
          if ($urandom_range(0, 19) == 0)
            send_byte(cft_pkg::MODE_END, 8'($urandom_range(0, 255)));
          else
            send_byte(cft_pkg::MODE_DATA, noise_char());
        end
      end else begin
        send_record($urandom_range(1, 6), (rec == 3) || ($urandom_range(0, 59) == 0),
                    1'b1);
      end
      rec++;
    end
    calm = 1'b0;

    // a last cell flushed by end of input
    send_byte(cft_pkg::MODE_DATA, plain_char());
    send_byte(cft_pkg::MODE_END, 8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    // drain with the output open, then watch for stray requests
    calm = 1'b1;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("PASS csv_field_tokenizer");
    end else begin
      $display("FAIL csv_field_tokenizer");
    end
    $finish;
  end

endmodule

### files.f
design/cft_pkg.sv
design/cft_front.sv
design/cft_queue.sv
design/cft_back.sv
design/csv_field_tokenizer.sv
test/csv_field_tokenizer_tb.sv
